// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Types, constants and a helper function shared by the box filter downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

    // field and store widths
    localparam int CHANNEL_BITS  = 16;
    localparam int SUM_BITS      = 22;
    localparam int NUM_CHANNELS  = 4;
    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_SCALE     = 8;
    localparam int COL_BITS      = $clog2(MAX_OUT_WIDTH);
    localparam int SC_BITS       = 13;
    localparam int SPAN_BITS     = SC_BITS + 1;
    localparam int RIB_BITS      = 3;
    localparam int SCALE_BITS    = 4;
    localparam int WIDTH_BITS    = 11;
    localparam int CH_SEL_BITS   = $clog2(NUM_CHANNELS);

    // reciprocal multiply: floor(n / d) == (n * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = SUM_BITS + 6;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // configuration register indexes
    localparam logic CFG_IDX_SCALE = 1'b0;
    localparam logic CFG_IDX_WIDTH = 1'b1;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(1);
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(MAX_OUT_WIDTH);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] in_red;
        logic [CHANNEL_BITS-1:0] in_green;
        logic [CHANNEL_BITS-1:0] in_blue;
        logic [CHANNEL_BITS-1:0] in_alpha;
        logic                    frame_start;
    } t_in_pix;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_red;
        logic [CHANNEL_BITS-1:0] out_green;
        logic [CHANNEL_BITS-1:0] out_blue;
        logic [CHANNEL_BITS-1:0] out_alpha;
        logic [COL_BITS-1:0]     out_column;
        logic                    row_end;
    } t_out_pix;

    typedef logic [NUM_CHANNELS-1:0][SUM_BITS-1:0] t_sums;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DIV_END,
        S_READ,
        S_ACC,
        S_MUL,
        S_QUO,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   div_step;
        logic                   div_end;
        logic                   acc;
        logic                   mul;
        logic                   quo;
        logic [CH_SEL_BITS-1:0] ch;
        logic                   emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic last;
        logic out_free;
    } t_dp_status;

    // ceil(2^RECIP_SHIFT / (f*f)) for an effective factor of 1..8
    function automatic logic [RECIP_BITS-1:0] recip(input logic [SCALE_BITS-1:0] f);
        logic [RECIP_BITS-1:0] r;
        case (f)
            4'd1:    r = RECIP_BITS'(268435456);
            4'd2:    r = RECIP_BITS'(67108864);
            4'd3:    r = RECIP_BITS'(29826162);
            4'd4:    r = RECIP_BITS'(16777216);
            4'd5:    r = RECIP_BITS'(10737419);
            4'd6:    r = RECIP_BITS'(7456541);
            4'd7:    r = RECIP_BITS'(5478275);
            4'd8:    r = RECIP_BITS'(4194304);
            default: r = RECIP_BITS'(268435456);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfd_ctrl
// Sequencer for the downsampler: accept, counter resync, row store
// read-modify-write, per-channel mean and result hand-off.
// ----------------------------------------------------------------------------
module bfd_ctrl
    import bfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state                 r_state, n_state;
    logic [SC_BITS-1:0]     r_step, n_step;
    logic [CH_SEL_BITS-1:0] r_ch, n_ch;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ch    <= n_ch;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_ch       = r_ch;
        o_cmd      = '0;
        o_cmd.ch   = r_ch;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = i_status.need_div ? S_DIV : S_READ;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == SC_BITS'(SC_BITS - 1)) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_READ;
            end
            S_READ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_ch      = '0;
                n_state   = i_status.last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_QUO;
            end
            S_QUO: begin
                o_cmd.quo = 1'b1;
                if (r_ch == CH_SEL_BITS'(NUM_CHANNELS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bfd_datapath.sv =====
// ----------------------------------------------------------------------------
// bfd_datapath
// Position counters, configuration registers, row sum store, shared
// reciprocal multiplier and the output register.
// ----------------------------------------------------------------------------
module bfd_datapath
    import bfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_pix               i_in_data,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_index,
    input  logic [WIDTH_BITS-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_pix              o_out_data
);

    logic [SCALE_BITS-1:0] r_scale;
    logic [WIDTH_BITS-1:0] r_width;
    logic                  r_dirty;
    logic [SC_BITS-1:0]    r_sc;
    logic [RIB_BITS-1:0]   r_rib;
    logic [COL_BITS-1:0]   r_col;
    logic [RIB_BITS-1:0]   r_sx;
    logic [SC_BITS-1:0]    r_dq;
    logic [SCALE_BITS-1:0] r_rem;
    t_in_pix               r_pix;
    t_sums                 r_rd;
    t_sums                 r_sum;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] r_quot;
    logic [PROD_BITS-1:0]  r_prod;
    logic [COL_BITS-1:0]   r_res_col;
    logic                  r_res_row_end;
    logic                  r_out_valid;
    t_out_pix              r_out;
    t_sums                 r_mem [MAX_OUT_WIDTH];

    logic [SCALE_BITS-1:0] f_eff;
    logic [WIDTH_BITS-1:0] w_eff;
    logic [SPAN_BITS-1:0]  span;
    logic                  restart_sc;
    logic                  restart_rib;
    logic [SPAN_BITS-1:0]  sc_inc;
    logic                  sc_wrap;
    logic [SCALE_BITS-1:0] sx_inc;
    logic [SCALE_BITS-1:0] rib_inc;
    logic                  first;
    logic                  last;
    logic [SCALE_BITS:0]   div_t;
    logic                  div_ge;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] pix_ch;
    t_sums                 n_sum;
    logic [CHANNEL_BITS-1:0] quot_sat;

    // effective factor and width after clamping
    always_comb begin
        if (r_scale == '0) begin
            f_eff = SCALE_BITS'(1);
        end else if (r_scale > SCALE_BITS'(MAX_SCALE)) begin
            f_eff = SCALE_BITS'(MAX_SCALE);
        end else begin
            f_eff = r_scale;
        end
        if (r_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (r_width > WIDTH_BITS'(MAX_OUT_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_OUT_WIDTH);
        end else begin
            w_eff = r_width;
        end
    end

    assign span = SPAN_BITS'(w_eff) * SPAN_BITS'(f_eff);

    // counter checks ahead of an incoming pixel
    assign restart_sc  = i_in_data.frame_start || ({1'b0, r_sc} >= span);
    assign restart_rib = i_in_data.frame_start || ({1'b0, r_rib} >= f_eff);

    // counter advance after a pixel
    assign sc_inc  = {1'b0, r_sc} + 1'b1;
    assign sc_wrap = sc_inc >= span;
    assign sx_inc  = {1'b0, r_sx} + 1'b1;
    assign rib_inc = {1'b0, r_rib} + 1'b1;

    // block corners
    assign first = (r_rib == '0) && (r_sx == '0);
    assign last  = (rib_inc == f_eff) && (sx_inc == f_eff);

    // restoring division step, column from source position
    assign div_t  = {r_rem, r_dq[SC_BITS-1]};
    assign div_ge = div_t >= {1'b0, f_eff};

    // running sums, channel 0 is red
    assign pix_ch = {r_pix.in_alpha, r_pix.in_blue, r_pix.in_green, r_pix.in_red};
    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_sum[c] = SUM_BITS'({{(SUM_BITS-CHANNEL_BITS){1'b0}}, pix_ch[c]}
                       + (first ? '0 : r_rd[c]));
        end
    end

    // quotient with saturation
    always_comb begin
        if (|r_prod[PROD_BITS-1:RECIP_SHIFT+CHANNEL_BITS]) begin
            quot_sat = '1;
        end else begin
            quot_sat = r_prod[RECIP_SHIFT +: CHANNEL_BITS];
        end
    end

    // config and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_width <= WIDTH_RESET;
            r_dirty <= 1'b0;
            r_sc    <= '0;
            r_rib   <= '0;
            r_col   <= '0;
            r_sx    <= '0;
        end else begin
            if (i_cmd.load) begin
                if (restart_sc) begin
                    r_sc    <= '0;
                    r_col   <= '0;
                    r_sx    <= '0;
                end
                if (restart_rib) begin
                    r_rib <= '0;
                end
            end
            if (i_cmd.div_end) begin
                r_col   <= r_dq[COL_BITS-1:0];
                r_sx    <= r_rem[RIB_BITS-1:0];
            end
            if (i_cmd.acc) begin
                if (sc_wrap) begin
                    r_sc  <= '0;
                    r_col <= '0;
                    r_sx  <= '0;
                    r_rib <= (rib_inc >= f_eff) ? '0 : rib_inc[RIB_BITS-1:0];
                end else begin
                    r_sc <= sc_inc[SC_BITS-1:0];
                    if (sx_inc == f_eff) begin
                        r_sx  <= '0;
                        r_col <= r_col + 1'b1;
                    end else begin
                        r_sx <= sx_inc[RIB_BITS-1:0];
                    end
                end
            end
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_IDX_SCALE: r_scale <= i_cfg_data[SCALE_BITS-1:0];
                    CFG_IDX_WIDTH: r_width <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // column and offset go stale on any register write
            if (i_cfg_wr) begin
                r_dirty <= 1'b1;
            end else if ((i_cmd.load && restart_sc) || i_cmd.div_end) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // pixel, divider and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_in_data;
            r_dq  <= restart_sc ? '0 : r_sc;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? SCALE_BITS'(div_t - {1'b0, f_eff}) : div_t[SCALE_BITS-1:0];
            r_dq  <= {r_dq[SC_BITS-2:0], div_ge};
        end
        if (i_cmd.acc) begin
            r_sum         <= n_sum;
            r_res_col     <= r_col;
            r_res_row_end <= ({1'b0, r_col} == (w_eff - 1'b1));
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_BITS'(r_sum[i_cmd.ch]) * PROD_BITS'(recip(f_eff));
        end
        if (i_cmd.quo) begin
            r_quot[i_cmd.ch] <= quot_sat;
        end
    end

    // row sum store
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_col];
        if (i_cmd.acc) begin
            r_mem[r_col] <= n_sum;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_red    <= r_quot[0];
            r_out.out_green  <= r_quot[1];
            r_out.out_blue   <= r_quot[2];
            r_out.out_alpha  <= r_quot[3];
            r_out.out_column <= r_res_col;
            r_out.row_end    <= r_res_row_end;
        end
    end

    assign o_status.need_div = r_dirty && !restart_sc;
    assign o_status.last     = last;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== rtl/box_filter_downsample.sv =====
// ----------------------------------------------------------------------------
// box_filter_downsample: RGBA box filter image downsampler
// A pixel passes read and accumulate states; a closing pixel then takes four multiply and
// quotient pairs and an emit state that waits for a free output. No new pixel is accepted
// until the last one is done, owing to the row store read-then-write and the one multiplier
// shared by four channels. The first pixel after a register write that does not restart the
// row adds a bit-serial column recompute. Reset clears counters, sets factor 1 and width 1024;
// row store not cleared.
module box_filter_downsample
    import bfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_pix               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_pix              o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [WIDTH_BITS-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_wr;

    // config writes land at any time
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    bfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // an accepted transaction blocks the input on the next cycle
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    // a result is only loaded into a free output register
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("result loaded over pending output");

    // a loaded result shows up as valid next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    // datapath work never overlaps an input accept
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step || cmd.acc || cmd.mul || cmd.quo) |-> o_in_stall)
        else $error("input accepted while datapath busy");
`endif

endmodule
